[src/lcgtpg_pkg.sv]
// ----------------------------------------------------------------------------
// lcgtpg_pkg
// Shared types, constants and helper functions for the LCG test-pattern
// generator and checker.
// ----------------------------------------------------------------------------
package lcgtpg_pkg;

	// LCG step constants and output byte position
	localparam logic [31:0] LCG_MUL    = 32'd1103515245;
	localparam logic [31:0] LCG_ADD    = 32'd12345;
	localparam int          OUT_SHIFT  = 16;
	localparam logic [31:0] SEED_RESET = 32'd1;

	// Buffer length limit and width of the reported position
	localparam int DEF_MAX_BUFFER_LEN = 65536;
	localparam int POS_OUT_W          = 17;

	typedef enum logic [1:0] {
		CMD_RESEED = 2'd0,
		CMD_GEN    = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] rx_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 mismatch;
		logic                 buffer_done;
		logic [POS_OUT_W-1:0] first_error_index;
	} result_t;

	// Advance one generator state
	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		return s * LCG_MUL + LCG_ADD;
	endfunction

	// Pick the pattern byte out of a state
	function automatic logic [7:0] lcg_byte(input logic [31:0] s);
		return s[OUT_SHIFT +: 8];
	endfunction

endpackage

[src/lcg_test_pattern_gen_check.sv]
// ----------------------------------------------------------------------------
// lcg_test_pattern_gen_check
// Top level: input register, transmit generator, receive checker and
// result register.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the result side is not stalled,
// and returns exactly one result beat for each, in order, through the input
// register and then the result register. Each generator state is fed back
// through a 32-bit multiply-add on each step of that generator. A reseed
// beat loads both generators from the seed register; writing seed alone
// changes nothing until the next reseed. The seed port is always ready, and
// should be written only while no beats are in flight.
module lcg_test_pattern_gen_check
	import lcgtpg_pkg::*;
#(
	parameter int MAX_BUFFER_LEN = DEF_MAX_BUFFER_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed
);

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic [31:0] seed_q;
	logic        adv;
	logic        fire;
	logic        tx_load;
	logic        tx_step;
	logic [7:0]  tx_byte;
	logic        rx_clear;
	logic        rx_check;
	result_t     chk_res;
	result_t     res_nxt;

	// Seed register, always ready
	assign seed_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_valid) begin
			seed_q <= seed;
		end
	end

	// Advance the pipe whenever the result register can take a beat
	assign adv        = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign fire       = valid_s1 && adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Decode the command into generator and checker strobes
	assign tx_load  = fire && (item_s1.command == CMD_RESEED);
	assign tx_step  = fire && (item_s1.command == CMD_GEN);
	assign rx_clear = tx_load;
	assign rx_check = fire && (item_s1.command == CMD_CHECK);

	lcgtpg_gen u_tx_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (tx_load),
		.step    (tx_step),
		.seed    (seed_q),
		.pattern (tx_byte)
	);

	lcgtpg_chk #(
		.MAX_BUFFER_LEN (MAX_BUFFER_LEN)
	) u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (rx_clear),
		.check   (rx_check),
		.rx_byte (item_s1.rx_byte),
		.last    (item_s1.last),
		.seed    (seed_q),
		.res     (chk_res)
	);

	// Select the result fields by command
	always_comb begin
		res_nxt = '0;
		unique case (item_s1.command)
			CMD_GEN: begin
				res_nxt.data_byte = tx_byte;
			end
			CMD_CHECK: begin
				res_nxt = chk_res;
			end
			CMD_RESEED, CMD_NOP: begin
				res_nxt = '0;
			end
			default: begin
				res_nxt = '0;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

[src/lcgtpg_gen.sv]
// ----------------------------------------------------------------------------
// lcgtpg_gen
// One 32-bit linear congruential generator: load from seed or step, and
// show the pattern byte of the next state.
// ----------------------------------------------------------------------------
module lcgtpg_gen
	import lcgtpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        step,
	input  logic [31:0] seed,
	output logic [7:0]  pattern
);

	logic [31:0] state_q;
	logic [31:0] state_nxt;

	// Compute the next state and its byte
	assign state_nxt = lcg_next(state_q);
	assign pattern   = lcg_byte(state_nxt);

	// Load on reseed, advance on step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_RESET;
		end else if (load) begin
			state_q <= seed;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/lcgtpg_chk.sv]
// ----------------------------------------------------------------------------
// lcgtpg_chk
// Receive-side checker: steps its own generator per compared byte, tracks
// the position in the buffer and the first mismatch, and reports at the
// byte marked last.
// ----------------------------------------------------------------------------
module lcgtpg_chk
	import lcgtpg_pkg::*;
#(
	parameter int MAX_BUFFER_LEN = DEF_MAX_BUFFER_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        check,
	input  logic [7:0]  rx_byte,
	input  logic        last,
	input  logic [31:0] seed,
	output result_t     res
);

	localparam int PW = $clog2(MAX_BUFFER_LEN + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_BUFFER_LEN);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] err_q;
	logic          failed_q;
	logic          step;
	logic [7:0]    expect_byte;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] err_new;
	logic          mis;
	logic          done;

	lcgtpg_gen u_rx_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (clear),
		.step    (step),
		.seed    (seed),
		.pattern (expect_byte)
	);

	// Compare only until the first failure in this buffer
	assign step    = check && !failed_q;
	assign pos_inc = (pos_q < POS_MAX) ? pos_q + PW'(1) : pos_q;
	assign mis     = step && (rx_byte != expect_byte);
	assign err_new = mis ? pos_inc : err_q;
	assign done    = check && last;

	// Form the checker's result fields
	always_comb begin
		res.data_byte         = step ? expect_byte : 8'd0;
		res.mismatch          = mis;
		res.buffer_done       = done;
		res.first_error_index = done ? POS_OUT_W'(err_new) : '0;
	end

	// Track position and first error; drop everything at buffer end or reseed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= '0;
			failed_q <= 1'b0;
		end else if (clear || done) begin
			pos_q    <= '0;
			err_q    <= '0;
			failed_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_inc;
			if (mis) begin
				err_q    <= pos_inc;
				failed_q <= 1'b1;
			end
		end
	end

endmodule

[src/lcgtpg_sva.sv]
// ----------------------------------------------------------------------------
// lcgtpg_sva
// Port-level checks for the LCG test-pattern generator and checker, bound
// to the top level.
// ----------------------------------------------------------------------------
module lcgtpg_sva
	import lcgtpg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_stall,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result
);

	// Hold a stalled result beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Stall the input only behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	// Report an error position only at buffer end
	a_index_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.buffer_done |-> result.first_error_index == '0)
		else $error("error index outside buffer end");

endmodule

bind lcg_test_pattern_gen_check lcgtpg_sva u_lcgtpg_sva (.*);

[sim/tb_lcg_test_pattern_gen_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg_test_pattern_gen_check
// Self-checking bench for the LCG pattern generator and checker. A scoreboard
// class tracks both generators and the buffer state, predicts one result per
// accepted beat and compares every returned beat field by field. Stimulus is
// a directed opening, then mostly well-formed check buffers built from the
// predicted pattern (with injected errors), mixed with random noise, under
// three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_lcg_test_pattern_gen_check;
	import lcgtpg_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned MAX_SHOWN    = 100;

	// Scoreboard: generator and buffer tracking plus expected result beats
	class lcg_pattern_scoreboard;
		logic [31:0] seed_value;
		logic [31:0] tx_state;
		logic [31:0] rx_state;
		int unsigned byte_pos;
		int unsigned err_pos;
		bit          buffer_failed;
		result_t     expected_beats[$];
		int unsigned errors;

		function new();
			seed_value = SEED_RESET;
			tx_state = SEED_RESET;
			rx_state = SEED_RESET;
			clear_buffer();
			errors = 0;
		endfunction

		function void clear_buffer();
			byte_pos = 0;
			err_pos = 0;
			buffer_failed = 1'b0;
		endfunction

		function logic [31:0] advance_lcg(input logic [31:0] s);
			return s * LCG_MUL + LCG_ADD;
		endfunction

		// Byte the receive side will compare against on the next check
		function logic [7:0] next_check_byte();
			logic [31:0] s;
			s = advance_lcg(rx_state);
			return s[OUT_SHIFT +: 8];
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		// Predict the result of an accepted beat
		function void note_item(input item_t it);
			result_t exp_r;
			exp_r = '0;
			case (it.command)
				CMD_RESEED: begin
					tx_state = seed_value;
					rx_state = seed_value;
					clear_buffer();
				end
				CMD_GEN: begin
					tx_state = advance_lcg(tx_state);
					exp_r.data_byte = tx_state[OUT_SHIFT +: 8];
				end
				CMD_CHECK: begin
					if (!buffer_failed) begin
						rx_state = advance_lcg(rx_state);
						exp_r.data_byte = rx_state[OUT_SHIFT +: 8];
						if (byte_pos < DEF_MAX_BUFFER_LEN)
							byte_pos++;
						if (it.rx_byte != exp_r.data_byte) begin
							exp_r.mismatch = 1'b1;
							buffer_failed = 1'b1;
							err_pos = byte_pos;
						end
					end
					if (it.last) begin
						exp_r.buffer_done = 1'b1;
						exp_r.first_error_index = err_pos[POS_OUT_W-1:0];
						clear_buffer();
					end
				end
				default: begin
				end
			endcase
			expected_beats.push_back(exp_r);
		endfunction

		task report(input string msg);
			if (errors < MAX_SHOWN)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// Compare one returned beat with the oldest expectation
		task check_result(input result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected result beat %h", got));
				return;
			end
			want = expected_beats.pop_front();
			if (got.data_byte !== want.data_byte)
				report($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
			if (got.mismatch !== want.mismatch)
				report($sformatf("mismatch got %b want %b", got.mismatch, want.mismatch));
			if (got.buffer_done !== want.buffer_done)
				report($sformatf("buffer_done got %b want %b",
					got.buffer_done, want.buffer_done));
			if (got.first_error_index !== want.first_error_index)
				report($sformatf("first_error_index got %0d want %0d",
					got.first_error_index, want.first_error_index));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        seed_valid = 1'b0;
	logic        seed_ready;
	logic [31:0] seed = '0;

	lcg_pattern_scoreboard sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned sent_count = 0;
	int unsigned cycle_count = 0;

	lcg_test_pattern_gen_check u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.seed_valid   (seed_valid),
		.seed_ready   (seed_ready),
		.seed         (seed)
	);

	always #6 clk = ~clk;

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receive side: check accepted beats, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(result);
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else if (hold_request != 0) begin
			hold_left = hold_request - 1;
			hold_request = 0;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Offer one beat, idling first at the sender rate, and hold it until taken
	task automatic send_beat(input cmd_t c, input logic [7:0] b, input logic l);
		item_t it;
		it.command = c;
		it.rx_byte = b;
		it.last = l;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_item(it);
		sent_count++;
	endtask

	// Drop valid and wait until every expected beat has come back
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		seed_valid <= 1'b1;
		seed <= value;
		do @(posedge clk); while (seed_ready !== 1'b1);
		sb.seed_value = value;
		seed_valid <= 1'b0;
	endtask

	task automatic send_random_beat();
		send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
	endtask

	// One check buffer of len bytes; corrupt byte bad_at and randomise the bytes after it (0 keeps it clean)
	task automatic run_buffer(input int unsigned len, input int unsigned bad_at);
		logic [7:0] b;
		for (int unsigned i = 1; i <= len; i++) begin
			b = sb.next_check_byte();
			if (i == bad_at)
				b = b ^ 8'($urandom_range(1, 255));
			else if (bad_at != 0 && i > bad_at)
				b = 8'($urandom);
			send_beat(CMD_CHECK, b, i == len);
			if (len < 1000 && $urandom_range(0, 11) == 0)
				send_beat($urandom_range(0, 1) ? CMD_GEN : CMD_NOP,
					8'($urandom), 1'($urandom));
		end
	endtask

	// Mostly well-formed buffers with random content, some noise bursts
	task automatic run_random(input int unsigned target);
		int unsigned start;
		int unsigned len;
		start = sent_count;
		while (sent_count - start < target) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 6)) send_random_beat();
			end else begin
				if ($urandom_range(0, 2) == 0)
					send_beat(CMD_RESEED, 8'($urandom), 1'($urandom));
				repeat ($urandom_range(0, 4))
					send_beat(CMD_GEN, 8'($urandom), 1'($urandom));
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300)
					: $urandom_range(1, 24);
				run_buffer(len, $urandom_range(0, 1) ? $urandom_range(1, len) : 0);
			end
		end
	endtask

	// Opening sequence from the reset state
	task automatic run_directed();
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b0);
		send_beat(CMD_GEN, 8'hff, 1'b1);
		send_beat(CMD_NOP, 8'hff, 1'b1);
		// error at the second byte, later bytes ignored until last
		send_beat(CMD_CHECK, ~sb.next_check_byte(), 1'b0);
		send_beat(CMD_CHECK, 8'h00, 1'b0);
		send_beat(CMD_CHECK, 8'hff, 1'b1);
		// single-byte buffers, clean and failing
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b1);
		send_beat(CMD_CHECK, ~sb.next_check_byte(), 1'b1);
		send_beat(CMD_RESEED, 8'hff, 1'b1);
		repeat (3) send_beat(CMD_GEN, 8'h00, 1'b0);
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b0);
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b0);
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b1);
		// reseed mid-buffer clears the failure
		send_beat(CMD_CHECK, ~sb.next_check_byte(), 1'b0);
		send_beat(CMD_RESEED, 8'h00, 1'b0);
		send_beat(CMD_CHECK, sb.next_check_byte(), 1'b1);
		send_beat(CMD_NOP, 8'h00, 1'b0);
		send_beat(CMD_CHECK, 8'h00, 1'b0);
		send_beat(CMD_CHECK, 8'hff, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 21;
		recv_idle_pct = 83;
		run_directed();
		wait_idle();
		write_seed(32'hffff_ffff);
		run_random(420);

		// sender idles heavily, receiver lightly
		wait_idle();
		send_idle_pct = 83;
		recv_idle_pct = 21;
		write_seed(32'h0000_0000);
		run_random(420);

		// no idling; long receiver hold while the sender keeps offering
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed($urandom);
		run_random(200);
		hold_request = HOLD_CYCLES;
		run_random(100);
		wait_idle();
		write_seed(SEED_RESET);
		send_beat(CMD_RESEED, 8'h00, 1'b0);
		run_random(160);

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
